// ===== sv/kmc_pkg.sv =====
// Shared types, codes and defaults for the k-nearest-neighbour median classifier.
package kmc_pkg;

  localparam int MAX_ROWS_DEF = 256;
  localparam int FEATURES_DEF = 8;
  localparam int K_MAX_DEF    = 16;

  localparam int FEAT_W  = 16;
  localparam int RANK_W  = 4;
  localparam int NDIST_W = 18;
  localparam int NC_W    = 5;
  localparam int OP_W    = 2;
  localparam int ERR_W   = 2;

  // input operation codes
  localparam logic [OP_W-1:0] OP_NEW   = 2'd0;
  localparam logic [OP_W-1:0] OP_TRAIN = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // result error codes
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_VOTE,
    S_GO,
    S_SQRT,
    S_OUT,
    S_ERR
  } state_t;

  typedef struct packed {
    logic             take;
    logic             query_start;
    logic             load_err;
    logic [ERR_W-1:0] err_code;
    logic             vote_step;
    logic             sqrt_start;
    logic             load_res;
    logic             advance;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_done;
    logic vote_last;
    logic sqrt_busy;
    logic last_out;
  } status_t;

endpackage

// ===== sv/kmc_isqrt.sv =====
// Multi-cycle integer square root, one result bit (two radicand bits) per step.
module kmc_isqrt #(
  parameter int IN_W = 35
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [IN_W-1:0]             din,
  output logic                        busy,
  output logic [(IN_W+1)/2-1:0]       root
);

  localparam int STEPS = (IN_W + 1) / 2;
  localparam int NW    = 2 * STEPS;
  localparam int CW    = $clog2(STEPS + 1);

  logic [NW-1:0] rem;
  logic [NW-1:0] res;
  logic [NW-1:0] bitv;
  logic [CW-1:0] cnt;
  logic [NW-1:0] trial;
  logic          ge;

  assign trial = res + bitv;
  assign ge    = (rem >= trial);
  assign root  = res[STEPS-1:0];

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == CW'(STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // one restoring step per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= NW'(din);
      res  <= '0;
      bitv <= NW'(1) << (NW - 2);
    end else if (busy) begin
      if (ge) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// ===== sv/kmc_dp.sv =====
// Datapath: training store, query registers, distance pipeline, neighbour list and vote.
module kmc_dp #(
  parameter int MAX_ROWS = kmc_pkg::MAX_ROWS_DEF,
  parameter int FEATURES = kmc_pkg::FEATURES_DEF,
  parameter int K_MAX    = kmc_pkg::K_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  kmc_pkg::cmd_t                       cmd,
  output kmc_pkg::status_t                    status,
  input  logic [kmc_pkg::OP_W-1:0]            op,
  input  logic signed [kmc_pkg::FEAT_W-1:0]   feature_value,
  input  logic signed [kmc_pkg::FEAT_W-1:0]   row_response,
  input  logic                                last_of_row,
  input  logic                                cfg_wen,
  input  logic [kmc_pkg::NC_W-1:0]            cfg_wdata,
  output logic [kmc_pkg::RANK_W-1:0]          rank,
  output logic signed [kmc_pkg::FEAT_W-1:0]   neighbour_response,
  output logic [kmc_pkg::NDIST_W-1:0]         neighbour_distance,
  output logic signed [kmc_pkg::FEAT_W-1:0]   prediction,
  output logic                                is_last,
  output logic [kmc_pkg::ERR_W-1:0]           error
);

  localparam int FW     = kmc_pkg::FEAT_W;
  localparam int FAW    = (MAX_ROWS * FEATURES > 1) ? $clog2(MAX_ROWS * FEATURES) : 1;
  localparam int RIW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RCW    = $clog2(MAX_ROWS + 1);
  localparam int FCW    = $clog2(FEATURES + 1);
  localparam int JW     = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int KW     = $clog2(K_MAX + 1);
  localparam int KIW    = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int DIST_W = 32 + $clog2(FEATURES);
  localparam int STEPS  = (DIST_W + 1) / 2;
  localparam int SATW   = (STEPS > kmc_pkg::NDIST_W) ? STEPS : kmc_pkg::NDIST_W;

  // storage
  logic signed [FW-1:0] fmem [MAX_ROWS*FEATURES];
  logic [FCW-1:0]       lmem [MAX_ROWS];
  logic signed [FW-1:0] rmem [MAX_ROWS];
  logic signed [FW-1:0] qf   [FEATURES];

  logic [RCW-1:0]          row_count;
  logic [FCW-1:0]          fcnt;
  logic [kmc_pkg::NC_W-1:0] ncount;
  logic [KW-1:0]           kk;
  logic [KW-1:0]           kk_calc;

  logic                    fc_room;
  logic [FCW-1:0]          fc_inc;
  logic                    full;
  logic                    tr_we;
  logic [RIW-1:0]          wrow;
  logic [FAW-1:0]          waddr;

  // scan issue
  logic                    issuing;
  logic [RIW-1:0]          sc_row;
  logic [JW-1:0]           sc_j;
  logic                    sc_j_last;
  logic                    sc_row_last;
  logic [FAW-1:0]          raddr;

  // stage 1
  logic                    v1;
  logic [JW-1:0]           j1;
  logic                    first1;
  logic                    last1;
  logic signed [FW-1:0]    f_rd;
  logic [FCW-1:0]          l_rd;
  logic signed [FW-1:0]    r_rd;
  logic signed [FW-1:0]    t_val;
  logic signed [FW:0]      diff;
  logic signed [2*FW+1:0]  prod;

  // stage 2
  logic                    v2;
  logic                    first2;
  logic                    last2;
  logic [31:0]             sq2;
  logic signed [FW-1:0]    resp2;

  // stage 3
  logic [DIST_W-1:0]       acc;
  logic [DIST_W-1:0]       sum;
  logic                    ins_v;
  logic [DIST_W-1:0]       ins_d;
  logic signed [FW-1:0]    ins_r;

  // neighbour list and vote buffer
  logic [DIST_W-1:0]       lst_d [K_MAX];
  logic signed [FW-1:0]    lst_r [K_MAX];
  logic [K_MAX-1:0]        keep;
  logic [KW-1:0]           filled;
  logic signed [FW-1:0]    vote [K_MAX];
  logic [K_MAX-1:0]        keepv;
  logic signed [FW-1:0]    vin;
  logic [KW-1:0]           vcnt;
  logic [KW-1:0]           oj;
  logic [KW-1:0]           kk_half;

  // root unit
  logic                    sq_busy;
  logic [STEPS-1:0]        sq_root;
  logic [kmc_pkg::NDIST_W-1:0] dist_sat;

  assign full    = (row_count == RCW'(MAX_ROWS));
  assign fc_room = (fcnt < FCW'(FEATURES));
  assign fc_inc  = fc_room ? fcnt + FCW'(1) : fcnt;
  assign tr_we   = cmd.take && (op == kmc_pkg::OP_TRAIN) && !full;
  assign wrow    = row_count[RIW-1:0];
  assign waddr   = FAW'(wrow) * FAW'(FEATURES) + FAW'(fcnt);

  // count rows and features, hold k
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      fcnt      <= '0;
      ncount    <= kmc_pkg::NC_W'(1);
    end else begin
      if (cfg_wen) begin
        ncount <= cfg_wdata;
      end
      if (cmd.take) begin
        if (op == kmc_pkg::OP_NEW) begin
          row_count <= '0;
          fcnt      <= '0;
        end else if (tr_we || op == kmc_pkg::OP_QUERY) begin
          fcnt <= last_of_row ? '0 : fc_inc;
          if (tr_we && last_of_row) begin
            row_count <= row_count + RCW'(1);
          end
        end
      end
    end
  end

  // write query features, zero the tail on the last element
  always_ff @(posedge clk) begin
    if (cmd.take && op == kmc_pkg::OP_QUERY) begin
      for (int j = 0; j < FEATURES; j++) begin
        if (fc_room && FCW'(j) == fcnt) begin
          qf[j] <= feature_value;
        end else if (last_of_row && FCW'(j) >= fc_inc) begin
          qf[j] <= '0;
        end
      end
    end
  end

  // training feature memory
  always_ff @(posedge clk) begin
    if (tr_we && fc_room) begin
      fmem[waddr] <= feature_value;
    end
    f_rd <= fmem[raddr];
  end

  // row length and response memories
  always_ff @(posedge clk) begin
    if (tr_we && last_of_row) begin
      lmem[wrow] <= fc_inc;
      rmem[wrow] <= row_response;
    end
    l_rd <= lmem[sc_row];
    r_rd <= rmem[sc_row];
  end

  // effective k for this query
  always_comb begin
    int k;
    k = (ncount == '0) ? 1 : int'(ncount);
    if (k > K_MAX) k = K_MAX;
    if (k > int'(row_count)) k = int'(row_count);
    kk_calc = KW'(k);
  end

  assign sc_j_last   = (sc_j == JW'(FEATURES - 1));
  assign sc_row_last = (RCW'(sc_row) + RCW'(1) == row_count);
  assign raddr       = FAW'(sc_row) * FAW'(FEATURES) + FAW'(sc_j);

  // issue one feature read per cycle over all rows
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      sc_row  <= '0;
      sc_j    <= '0;
    end else if (cmd.query_start) begin
      issuing <= 1'b1;
      sc_row  <= '0;
      sc_j    <= '0;
    end else if (issuing) begin
      if (sc_j_last) begin
        sc_j   <= '0;
        sc_row <= sc_row + RIW'(1);
        if (sc_row_last) begin
          issuing <= 1'b0;
        end
      end else begin
        sc_j <= sc_j + JW'(1);
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      ins_v <= 1'b0;
    end else begin
      v1    <= issuing;
      v2    <= v1;
      ins_v <= v2 && last2;
    end
  end

  assign t_val = (FCW'(j1) < l_rd) ? f_rd : '0;
  assign diff  = {qf[j1][FW-1], qf[j1]} - {t_val[FW-1], t_val};
  assign prod  = diff * diff;
  assign sum   = (first2 ? '0 : acc) + DIST_W'(sq2);

  // square and accumulate
  always_ff @(posedge clk) begin
    j1     <= sc_j;
    first1 <= (sc_j == '0);
    last1  <= sc_j_last;
    sq2    <= prod[31:0];
    first2 <= first1;
    last2  <= last1;
    resp2  <= r_rd;
    if (v2) begin
      acc <= sum;
    end
    ins_d <= sum;
    ins_r <= resp2;
  end

  // sorted insert into the neighbour list, ties keep the earlier row
  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      keep[i] = (KW'(i) < filled) && !(lst_d[i] > ins_d);
    end
  end

  always_ff @(posedge clk) begin
    if (ins_v) begin
      for (int i = 0; i < K_MAX; i++) begin
        if (!keep[i]) begin
          if (i == 0) begin
            lst_d[i] <= ins_d;
            lst_r[i] <= ins_r;
          end else if (keep[i-1]) begin
            lst_d[i] <= ins_d;
            lst_r[i] <= ins_r;
          end else begin
            lst_d[i] <= lst_d[i-1];
            lst_r[i] <= lst_r[i-1];
          end
        end
      end
    end
  end

  // sorted insert of responses for the median
  assign vin = lst_r[vcnt[KIW-1:0]];

  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      keepv[i] = (KW'(i) < vcnt) && !(vote[i] > vin);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vote_step) begin
      for (int i = 0; i < K_MAX; i++) begin
        if (!keepv[i]) begin
          if (i == 0) begin
            vote[i] <= vin;
          end else if (keepv[i-1]) begin
            vote[i] <= vin;
          end else begin
            vote[i] <= vote[i-1];
          end
        end
      end
    end
  end

  // list, vote and output counters
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      vcnt   <= '0;
      oj     <= '0;
      kk     <= KW'(1);
    end else if (cmd.query_start) begin
      filled <= '0;
      vcnt   <= '0;
      oj     <= '0;
      kk     <= kk_calc;
    end else begin
      if (ins_v && filled < kk) begin
        filled <= filled + KW'(1);
      end
      if (cmd.vote_step) begin
        vcnt <= vcnt + KW'(1);
      end
      if (cmd.advance) begin
        oj <= oj + KW'(1);
      end
    end
  end

  kmc_isqrt #(
    .IN_W (DIST_W)
  ) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .din   (lst_d[oj[KIW-1:0]]),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  assign dist_sat = (SATW'(sq_root) > SATW'({kmc_pkg::NDIST_W{1'b1}})) ?
                    {kmc_pkg::NDIST_W{1'b1}} : kmc_pkg::NDIST_W'(sq_root);
  assign kk_half  = kk >> 1;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      rank               <= '0;
      neighbour_response <= '0;
      neighbour_distance <= '0;
      prediction         <= '0;
      is_last            <= 1'b1;
      error              <= cmd.err_code;
    end else if (cmd.load_res) begin
      rank               <= kmc_pkg::RANK_W'(oj);
      neighbour_response <= lst_r[oj[KIW-1:0]];
      neighbour_distance <= dist_sat;
      prediction         <= vote[kk_half[KIW-1:0]];
      is_last            <= (oj == kk - KW'(1));
      error              <= kmc_pkg::ERR_NONE;
    end
  end

  assign status.full      = full;
  assign status.empty     = (row_count == '0);
  assign status.scan_done = !issuing && !v1 && !v2 && !ins_v;
  assign status.vote_last = (vcnt == kk - KW'(1));
  assign status.sqrt_busy = sq_busy;
  assign status.last_out  = (oj == kk - KW'(1));

endmodule

// ===== sv/kmc_ctrl.sv =====
// Controller: sequences accept, scan, vote, root and result delivery.
module kmc_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [kmc_pkg::OP_W-1:0] op,
  input  logic                     last_of_row,
  input  logic                     out_ready,
  input  kmc_pkg::status_t         status,
  output logic                     in_ready,
  output logic                     out_valid,
  output kmc_pkg::cmd_t            cmd
);

  kmc_pkg::state_t state;
  kmc_pkg::state_t state_next;
  logic            accept;
  logic            is_query_end;
  logic            is_train;

  assign accept       = in_valid && (state == kmc_pkg::S_IDLE);
  assign is_query_end = (op == kmc_pkg::OP_QUERY) && last_of_row;
  assign is_train     = (op == kmc_pkg::OP_TRAIN);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kmc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      kmc_pkg::S_IDLE: begin
        if (accept) begin
          if (is_train && status.full) begin
            state_next = kmc_pkg::S_ERR;
          end else if (is_query_end && status.empty) begin
            state_next = kmc_pkg::S_ERR;
          end else if (is_query_end) begin
            state_next = kmc_pkg::S_SCAN;
          end
        end
      end
      kmc_pkg::S_SCAN: begin
        if (status.scan_done) state_next = kmc_pkg::S_VOTE;
      end
      kmc_pkg::S_VOTE: begin
        if (status.vote_last) state_next = kmc_pkg::S_GO;
      end
      kmc_pkg::S_GO: begin
        state_next = kmc_pkg::S_SQRT;
      end
      kmc_pkg::S_SQRT: begin
        if (!status.sqrt_busy) state_next = kmc_pkg::S_OUT;
      end
      kmc_pkg::S_OUT: begin
        if (out_ready) begin
          state_next = status.last_out ? kmc_pkg::S_IDLE : kmc_pkg::S_GO;
        end
      end
      kmc_pkg::S_ERR: begin
        if (out_ready) state_next = kmc_pkg::S_IDLE;
      end
      default: state_next = kmc_pkg::S_IDLE;
    endcase
  end

  // commands and handshake
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      kmc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = accept;
        if (accept) begin
          if (is_train && status.full) begin
            cmd.load_err = 1'b1;
            cmd.err_code = kmc_pkg::ERR_FULL;
          end else if (is_query_end && status.empty) begin
            cmd.load_err = 1'b1;
            cmd.err_code = kmc_pkg::ERR_EMPTY;
          end else if (is_query_end) begin
            cmd.query_start = 1'b1;
          end
        end
      end
      kmc_pkg::S_SCAN: begin
      end
      kmc_pkg::S_VOTE: begin
        cmd.vote_step = 1'b1;
      end
      kmc_pkg::S_GO: begin
        cmd.sqrt_start = 1'b1;
      end
      kmc_pkg::S_SQRT: begin
        cmd.load_res = !status.sqrt_busy;
      end
      kmc_pkg::S_OUT: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready && !status.last_out;
      end
      kmc_pkg::S_ERR: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/knn_median_classifier_unit.sv =====
// Top level of the k-nearest-neighbour median classifier.
//
// Input channel (in_valid/in_ready): one beat per feature. op 0 starts a new
// training set, op 1 writes a training feature (last_of_row closes the row and
// takes row_response), op 2 writes a query feature. Beats that give no result
// leave the block idle. in_ready is high only while the block is idle.
// On a query's closing beat the block reads every stored feature once, one
// feature per cycle from the feature memory port, then orders the k nearest
// responses for the median. Each of the k results then passes through the
// square root unit before it is shown on the output register.
// Output channel (out_valid/out_ready): results come nearest first; is_last
// marks the final one. While the receiver stalls the result holds and no
// further work is done. Error results (empty set, full store) are single beats.
// The user must write neighbour_count (cfg_wen/cfg_wdata) only while idle;
// the block does not enforce this. Reset clears the row and feature counts
// and sets k to 1; the stores need no clearing, so the block leaves reset idle.
module knn_median_classifier_unit #(
  parameter int MAX_ROWS = kmc_pkg::MAX_ROWS_DEF,
  parameter int FEATURES = kmc_pkg::FEATURES_DEF,
  parameter int K_MAX    = kmc_pkg::K_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [kmc_pkg::OP_W-1:0]            op,
  input  logic signed [kmc_pkg::FEAT_W-1:0]   feature_value,
  input  logic signed [kmc_pkg::FEAT_W-1:0]   row_response,
  input  logic                                last_of_row,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [kmc_pkg::RANK_W-1:0]          rank,
  output logic signed [kmc_pkg::FEAT_W-1:0]   neighbour_response,
  output logic [kmc_pkg::NDIST_W-1:0]         neighbour_distance,
  output logic signed [kmc_pkg::FEAT_W-1:0]   prediction,
  output logic                                is_last,
  output logic [kmc_pkg::ERR_W-1:0]           error,
  input  logic                                cfg_wen,
  input  logic [kmc_pkg::NC_W-1:0]            cfg_wdata
);

  kmc_pkg::cmd_t    cmd;
  kmc_pkg::status_t status;

  kmc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .op          (op),
    .last_of_row (last_of_row),
    .out_ready   (out_ready),
    .status      (status),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .cmd         (cmd)
  );

  kmc_dp #(
    .MAX_ROWS (MAX_ROWS),
    .FEATURES (FEATURES),
    .K_MAX    (K_MAX)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .op                 (op),
    .feature_value      (feature_value),
    .row_response       (row_response),
    .last_of_row        (last_of_row),
    .cfg_wen            (cfg_wen),
    .cfg_wdata          (cfg_wdata),
    .rank               (rank),
    .neighbour_response (neighbour_response),
    .neighbour_distance (neighbour_distance),
    .prediction         (prediction),
    .is_last            (is_last),
    .error              (error)
  );

endmodule

// ===== sv/kmc_checker.sv =====
// Port-level checks for the classifier, bound to the top level.
module kmc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [kmc_pkg::RANK_W-1:0]          rank,
  input logic [kmc_pkg::NDIST_W-1:0]         neighbour_distance,
  input logic signed [kmc_pkg::FEAT_W-1:0]   prediction,
  input logic                                is_last,
  input logic [kmc_pkg::ERR_W-1:0]           error
);

  // never take input while a result is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // error beats are single, zeroed results
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && error != kmc_pkg::ERR_NONE |-> is_last && rank == '0 && prediction == '0)
    else $error("error result malformed");

  // more results follow a non-final beat before new input is taken
  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !is_last |=> !in_ready)
    else $error("input taken inside a result burst");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rank) && $stable(neighbour_distance))
    else $error("stalled result changed");

  // reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind knn_median_classifier_unit kmc_checker u_kmc_checker (.*);
